// ===== rtl/core/dtw_pkg.sv =====
`timescale 1ns / 1ps

package dtw_pkg;

  localparam logic [1:0] MODE_READ  = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_TICK  = 2'd2;

  localparam logic [6:0] OFS_T0_DIV  = 7'h00;
  localparam logic [6:0] OFS_T0_DATA = 7'h04;
  localparam logic [6:0] OFS_T0_CTRL = 7'h08;
  localparam logic [6:0] OFS_T1_DIV  = 7'h10;
  localparam logic [6:0] OFS_T1_DATA = 7'h14;
  localparam logic [6:0] OFS_T1_CTRL = 7'h18;
  localparam logic [6:0] OFS_TIME    = 7'h38;
  localparam logic [6:0] OFS_WD_CTRL = 7'h40;
  localparam logic [6:0] OFS_MASK    = 7'h48;
  localparam logic [6:0] OFS_ACK     = 7'h4c;
  localparam logic [6:0] OFS_MASKED  = 7'h54;

  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_HOLD = 2'd1;
  localparam logic [1:0] OP_RUN  = 2'd2;

  localparam logic [8:0] WD_ZERO_LOAD = 9'd256;

  typedef struct packed {
    logic wr_div;
    logic wr_ctrl;
    logic tick;
  } timer_ctl_t;

  typedef struct packed {
    logic wr;
    logic tick;
  } wd_ctl_t;

endpackage

// ===== rtl/core/dual_timer_watchdog_regs.sv =====
`timescale 1ns / 1ps

// Two down-counting timers, an interrupt mask and acknowledge pair, a keyed
// watchdog and a free-running time counter, driven by a request stream.
// Each request on the slave side is a bus read, a bus write or a time tick,
// selected by s_tuser; s_tdata carries the address, write data and pulses.
// Every request produces exactly one response on the master side, holding
// the read data (zero for anything but a readable register) and the irq,
// nmi and reset request levels after the request has been applied.
// A request passes through an input register and then a response register
// before its response is offered on the master side.
// One request is accepted every cycle while the master side keeps taking
// responses.
// When the receiver stalls, the response register holds and the input
// register stops, so s_tready falls until the response is taken.
// A synchronous reset clears all timers, the watchdog, the mask, the pending
// interrupts and the time counter, and empties both registers.
module dual_timer_watchdog_regs #(
  parameter int WD_GRACE = 10
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [6:0] addr, [38:7] wdata, [42:39] src_pulses, [43] wd_pulse,
  // [44] time_pulse, rest zero
  input  logic [47:0] s_tdata,
  // [1:0] mode
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [31:0] rdata, [32] irq_out, [33] nmi_out, [34] reset_request, rest zero
  output logic [39:0] m_tdata
);
  import dtw_pkg::*;

  logic        advance;
  logic        fire;

  logic        s1_valid;
  logic [1:0]  s1_mode;
  logic [6:0]  s1_addr;
  logic [31:0] s1_wdata;
  logic [3:0]  s1_pulses;
  logic        s1_wd_pulse;
  logic        s1_time_pulse;

  logic [31:0] intr_mask;
  logic [1:0]  pending;
  logic [31:0] time_counter;
  logic [31:0] intr_mask_next;
  logic [1:0]  pending_next;

  timer_ctl_t  t0_ctl;
  timer_ctl_t  t1_ctl;
  wd_ctl_t     wd_ctl;
  logic [31:0] t0_count;
  logic [31:0] t1_count;
  logic        t0_expire;
  logic        t1_expire;
  logic        wd_nmi_next;
  logic        wd_reset_req;

  logic        is_read;
  logic        is_write;
  logic        is_tick;
  logic [31:0] rdata;

  logic [31:0] out_rdata;
  logic        out_irq;
  logic        out_nmi;
  logic        out_reset_req;

  assign advance  = !m_tvalid || m_tready;
  assign s_tready = advance;
  assign fire     = advance && s1_valid;

  always_comb begin
    is_read  = fire && (s1_mode == MODE_READ);
    is_write = fire && (s1_mode == MODE_WRITE);
    is_tick  = fire && (s1_mode == MODE_TICK);

    t0_ctl.wr_div  = is_write && (s1_addr == OFS_T0_DIV);
    t0_ctl.wr_ctrl = is_write && (s1_addr == OFS_T0_CTRL);
    t0_ctl.tick    = is_tick;
    t1_ctl.wr_div  = is_write && (s1_addr == OFS_T1_DIV);
    t1_ctl.wr_ctrl = is_write && (s1_addr == OFS_T1_CTRL);
    t1_ctl.tick    = is_tick;
    wd_ctl.wr      = is_write && (s1_addr == OFS_WD_CTRL);
    wd_ctl.tick    = is_tick && s1_wd_pulse;

    intr_mask_next = (is_write && (s1_addr == OFS_MASK)) ? s1_wdata : intr_mask;
    pending_next   = pending | {t1_expire, t0_expire};
    if (is_write && (s1_addr == OFS_ACK)) begin
      pending_next = pending & ~s1_wdata[1:0];
    end

    rdata = '0;
    if (is_read) begin
      case (s1_addr)
        OFS_T0_DATA: rdata = t0_count;
        OFS_T1_DATA: rdata = t1_count;
        OFS_TIME:    rdata = time_counter;
        OFS_MASK:    rdata = intr_mask;
        OFS_MASKED:  rdata = {30'd0, pending & intr_mask[1:0]};
        default:     rdata = '0;
      endcase
    end
  end

  dtw_timer u_timer0 (
    .clk    (clk),
    .rst    (rst),
    .ctl    (t0_ctl),
    .wdata  (s1_wdata),
    .pulses (s1_pulses),
    .count  (t0_count),
    .expire (t0_expire)
  );

  dtw_timer u_timer1 (
    .clk    (clk),
    .rst    (rst),
    .ctl    (t1_ctl),
    .wdata  (s1_wdata),
    .pulses (s1_pulses),
    .count  (t1_count),
    .expire (t1_expire)
  );

  dtw_watchdog #(
    .WD_GRACE (WD_GRACE)
  ) u_watchdog (
    .clk       (clk),
    .rst       (rst),
    .ctl       (wd_ctl),
    .wdata     (s1_wdata[15:0]),
    .nmi_next  (wd_nmi_next),
    .reset_req (wd_reset_req)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      m_tvalid     <= 1'b0;
      intr_mask    <= '0;
      pending      <= '0;
      time_counter <= '0;
    end else begin
      if (advance) begin
        s1_valid <= s_tvalid;
        m_tvalid <= s1_valid;
      end
      intr_mask <= intr_mask_next;
      pending   <= pending_next;
      if (is_tick && s1_time_pulse) begin
        time_counter <= time_counter + 32'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_mode       <= s_tuser;
      s1_addr       <= s_tdata[6:0];
      s1_wdata      <= s_tdata[38:7];
      s1_pulses     <= s_tdata[42:39];
      s1_wd_pulse   <= s_tdata[43];
      s1_time_pulse <= s_tdata[44];
    end
    if (fire) begin
      out_rdata     <= rdata;
      out_irq       <= ((pending_next & intr_mask_next[1:0]) != 2'd0);
      out_nmi       <= wd_nmi_next;
      out_reset_req <= wd_reset_req;
    end
  end

  assign m_tdata = {5'd0, out_reset_req, out_nmi, out_irq, out_rdata};

  a_reset_req_has_nmi: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_reset_req) |-> out_nmi)
    else $error("reset request without a prior watchdog expiry");

  a_read_keeps_time: assert property (@(posedge clk) disable iff (rst)
    (fire && (s1_mode == MODE_READ)) |=> $stable(time_counter))
    else $error("time counter moved on a read");

  a_no_pending_without_tick: assert property (@(posedge clk) disable iff (rst)
    !is_tick |-> (!t0_expire && !t1_expire))
    else $error("timer expired outside a tick");

  a_fire_fills_output: assert property (@(posedge clk) disable iff (rst)
    fire |=> m_tvalid)
    else $error("response lost after an accepted request");

endmodule

// ===== rtl/core/dtw_timer.sv =====
`timescale 1ns / 1ps

module dtw_timer (
  input  logic                clk,
  input  logic                rst,
  input  dtw_pkg::timer_ctl_t ctl,
  input  logic [31:0]         wdata,
  input  logic [3:0]          pulses,
  output logic [31:0]         count,
  output logic                expire
);
  import dtw_pkg::*;

  logic [31:0] divider;
  logic        running;
  logic [2:0]  src;
  logic        counting;

  always_comb begin
    counting = ctl.tick && running && src[2] && pulses[src[1:0]];
    expire   = counting && (count[31:1] == 31'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      divider <= '0;
      count   <= '0;
      running <= 1'b0;
      src     <= '0;
    end else begin
      if (ctl.wr_div) begin
        divider <= wdata;
      end
      if (ctl.wr_ctrl) begin
        src <= wdata[4:2];
        case (wdata[1:0])
          OP_LOAD: count   <= divider;
          OP_HOLD: running <= 1'b0;
          OP_RUN:  running <= 1'b1;
          default: ;
        endcase
      end
      if (counting) begin
        count <= expire ? divider : count - 32'd1;
      end
    end
  end

endmodule

// ===== rtl/core/dtw_watchdog.sv =====
`timescale 1ns / 1ps

module dtw_watchdog #(
  parameter int WD_GRACE = 10
) (
  input  logic             clk,
  input  logic             rst,
  input  dtw_pkg::wd_ctl_t ctl,
  input  logic [15:0]      wdata,
  output logic             nmi_next,
  output logic             reset_req
);
  import dtw_pkg::*;

  localparam logic [8:0] GRACE_LOAD = 9'(WD_GRACE);

  logic [15:0] control;
  logic [8:0]  count;
  logic        running;
  logic [1:0]  expiries;

  logic [15:0] control_next;
  logic [8:0]  count_next;
  logic        running_next;
  logic [1:0]  expiries_next;
  logic        key_ok;

  always_comb begin
    control_next  = control;
    count_next    = count;
    running_next  = running;
    expiries_next = expiries;
    reset_req     = 1'b0;
    key_ok        = !control[8] || (~control[15:9] == wdata[15:9]);
    if (ctl.wr && key_ok) begin
      expiries_next = 2'd0;
      count_next    = (wdata[8:0] == 9'd0) ? WD_ZERO_LOAD : wdata[8:0];
      running_next  = wdata[8];
      control_next  = wdata;
    end else if (ctl.tick && running) begin
      if (count <= 9'd1) begin
        if (expiries == 2'd0) begin
          count_next = GRACE_LOAD;
        end else begin
          reset_req    = 1'b1;
          count_next   = 9'd0;
          running_next = 1'b0;
        end
        if (expiries != 2'd3) begin
          expiries_next = expiries + 2'd1;
        end
      end else begin
        count_next = count - 9'd1;
      end
    end
    nmi_next = (expiries_next != 2'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      control  <= '0;
      count    <= '0;
      running  <= 1'b0;
      expiries <= '0;
    end else begin
      control  <= control_next;
      count    <= count_next;
      running  <= running_next;
      expiries <= expiries_next;
    end
  end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import dtw_pkg::*;

  localparam int WD_GRACE = 10;
  localparam int RANDOM_ITEMS = 800;
  localparam int QUIET_ITEMS = 100;
  localparam int CYCLE_LIMIT = 200000;
  localparam int LONG_STALL = 60;
  localparam logic [1:0] MODE_NONE = 2'd3;
  localparam logic [1:0] OP_KEEP = 2'd3;
  localparam logic [2:0] SRC_FIRST_CLOCK = 3'd4;
  localparam logic [6:0] OFS_UNMAPPED = 7'h7c;
  localparam logic [6:0] READABLE_OFS [5] =
    '{OFS_T0_DATA, OFS_T1_DATA, OFS_TIME, OFS_MASK, OFS_MASKED};

  typedef struct packed {
    logic [1:0]  mode;
    logic [6:0]  addr;
    logic [31:0] wdata;
    logic [3:0]  src_pulses;
    logic        wd_pulse;
    logic        time_pulse;
  } request_t;

  typedef struct packed {
    logic [31:0] rdata;
    logic        irq;
    logic        nmi;
    logic        reset_request;
  } response_t;

  class timer_regs_scoreboard;
    bit [31:0] divider [2];
    bit [31:0] timer_count [2];
    bit        timer_running [2];
    bit [2:0]  source_sel [2];
    bit [1:0]  pending;
    bit [31:0] intr_mask;
    bit [15:0] wd_control;
    bit [8:0]  wd_count;
    bit        wd_running;
    bit [1:0]  wd_expiries;
    bit [31:0] time_count;
    response_t expected_responses [$];
    int unsigned mismatches;
    int unsigned checked;
    int unsigned irq_seen;
    int unsigned nmi_seen;
    int unsigned resets_seen;

    function int outstanding();
      return expected_responses.size();
    endfunction

    function bit [6:0] next_wd_key();
      return ~wd_control[15:9];
    endfunction

    function void write_timer_ctrl(int n, bit [31:0] v);
      source_sel[n] = v[4:2];
      case (v[1:0])
        OP_LOAD: timer_count[n] = divider[n];
        OP_HOLD: timer_running[n] = 1'b0;
        OP_RUN:  timer_running[n] = 1'b1;
        default: ;
      endcase
    endfunction

    function void tick_timer(int n, bit [3:0] pulses);
      if (!timer_running[n] || source_sel[n] < SRC_FIRST_CLOCK) return;
      if (!pulses[source_sel[n] - SRC_FIRST_CLOCK]) return;
      if (timer_count[n] <= 1) begin
        pending[n] = 1'b1;
        timer_count[n] = divider[n];
      end else begin
        timer_count[n] = timer_count[n] - 32'd1;
      end
    endfunction

    function void note_request(request_t r);
      response_t res;
      bit [8:0] cnt;
      res = '0;
      case (r.mode)
        MODE_READ: begin
          case (r.addr)
            OFS_T0_DATA: res.rdata = timer_count[0];
            OFS_T1_DATA: res.rdata = timer_count[1];
            OFS_TIME:    res.rdata = time_count;
            OFS_MASK:    res.rdata = intr_mask;
            OFS_MASKED:  res.rdata = {30'd0, pending} & intr_mask;
            default: ;
          endcase
        end
        MODE_WRITE: begin
          case (r.addr)
            OFS_T0_DIV:  divider[0] = r.wdata;
            OFS_T0_CTRL: write_timer_ctrl(0, r.wdata);
            OFS_T1_DIV:  divider[1] = r.wdata;
            OFS_T1_CTRL: write_timer_ctrl(1, r.wdata);
            OFS_MASK:    intr_mask = r.wdata;
            OFS_ACK:     pending = pending & ~r.wdata[1:0];
            OFS_WD_CTRL: begin
              if (!wd_control[8] || next_wd_key() == r.wdata[15:9]) begin
                cnt = r.wdata[8:0];
                wd_expiries = 2'd0;
                wd_count = (cnt == 9'd0) ? WD_ZERO_LOAD : cnt;
                wd_running = r.wdata[8];
                wd_control = r.wdata[15:0];
              end
            end
            default: ;
          endcase
        end
        MODE_TICK: begin
          tick_timer(0, r.src_pulses);
          tick_timer(1, r.src_pulses);
          if (r.wd_pulse && wd_running) begin
            if (wd_count <= 1) begin
              if (wd_expiries == 2'd0) begin
                wd_count = 9'(WD_GRACE);
              end else begin
                res.reset_request = 1'b1;
                wd_count = 9'd0;
                wd_running = 1'b0;
              end
              if (wd_expiries < 2'd3) wd_expiries = wd_expiries + 2'd1;
            end else begin
              wd_count = wd_count - 9'd1;
            end
          end
          if (r.time_pulse) time_count = time_count + 32'd1;
        end
        default: ;
      endcase
      res.irq = (({30'd0, pending} & intr_mask) != 32'd0);
      res.nmi = (wd_expiries != 2'd0);
      expected_responses.push_back(res);
    endfunction

    function void report(string what, response_t exp_r, response_t got);
      mismatches++;
      if (mismatches <= 10)
        $display("%s: expected rdata=%h irq=%b nmi=%b rst=%b, got rdata=%h irq=%b nmi=%b rst=%b",
                 what, exp_r.rdata, exp_r.irq, exp_r.nmi, exp_r.reset_request,
                 got.rdata, got.irq, got.nmi, got.reset_request);
    endfunction

    function void check_response(logic [39:0] data);
      response_t got;
      response_t exp_r;
      got.rdata = data[31:0];
      got.irq = data[32];
      got.nmi = data[33];
      got.reset_request = data[34];
      if (expected_responses.size() == 0) begin
        report("Response with no request pending", '0, got);
        return;
      end
      exp_r = expected_responses.pop_front();
      checked++;
      irq_seen += got.irq;
      nmi_seen += got.nmi;
      resets_seen += got.reset_request;
      if (got.rdata !== exp_r.rdata || got.irq !== exp_r.irq ||
          got.nmi !== exp_r.nmi || got.reset_request !== exp_r.reset_request)
        report($sformatf("Mismatch on response %0d", checked), exp_r, got);
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [47:0] s_tdata;
  logic [1:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;

  timer_regs_scoreboard regs_sb;
  bit quiet;
  bit stall_receiver;
  int unsigned cycles;
  int unsigned reads_sent;
  int unsigned writes_sent;
  int unsigned ticks_sent;

  dual_timer_watchdog_regs #(
    .WD_GRACE(WD_GRACE)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic request_t make_req(logic [1:0] mode, logic [6:0] addr,
                                        logic [31:0] wdata, logic [3:0] pulses,
                                        logic wd, logic tp);
    request_t r;
    r.mode = mode;
    r.addr = addr;
    r.wdata = wdata;
    r.src_pulses = pulses;
    r.wd_pulse = wd;
    r.time_pulse = tp;
    return r;
  endfunction

  function automatic request_t random_request();
    request_t r;
    int pick;
    r = make_req(MODE_TICK, 7'($urandom_range(0, 127)), $urandom(),
                 4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)));
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      r.mode = MODE_TICK;
    end else if (pick < 62) begin
      r.mode = MODE_READ;
      if ($urandom_range(0, 4) != 0) r.addr = READABLE_OFS[$urandom_range(0, 4)];
    end else if (pick < 95) begin
      r.mode = MODE_WRITE;
      case ($urandom_range(0, 9))
        0, 1: begin
          r.addr = $urandom_range(0, 1) ? OFS_T1_DIV : OFS_T0_DIV;
          if ($urandom_range(0, 7) != 0) r.wdata = $urandom_range(0, 12);
        end
        2, 3: begin
          r.addr = $urandom_range(0, 1) ? OFS_T1_CTRL : OFS_T0_CTRL;
          if ($urandom_range(0, 3) != 0) r.wdata[4:2] = 3'($urandom_range(4, 7));
        end
        4: begin
          r.addr = OFS_MASK;
          if ($urandom_range(0, 1)) r.wdata = $urandom_range(0, 3);
        end
        5: begin
          r.addr = OFS_ACK;
          if ($urandom_range(0, 1)) r.wdata = $urandom_range(0, 3);
        end
        6, 7, 8: begin
          r.addr = OFS_WD_CTRL;
          if ($urandom_range(0, 4) != 0) begin
            r.wdata[15:9] = regs_sb.next_wd_key();
            r.wdata[8] = ($urandom_range(0, 4) != 0);
            r.wdata[7:0] = ($urandom_range(0, 4) == 0) ? 8'($urandom()) :
                                                         8'($urandom_range(0, 12));
          end
        end
        default: ;
      endcase
    end else begin
      r.mode = MODE_NONE;
    end
    return r;
  endfunction

  task automatic send_request(request_t r);
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata <= {3'b000, r.time_pulse, r.wd_pulse, r.src_pulses, r.wdata, r.addr};
    s_tuser <= r.mode;
    do @(posedge clk); while (!s_tready);
    regs_sb.note_request(r);
    case (r.mode)
      MODE_READ:  reads_sent++;
      MODE_WRITE: writes_sent++;
      MODE_TICK:  ticks_sent++;
      default: ;
    endcase
  endtask

  task automatic pause_sender(int n);
    @(negedge clk);
    s_tvalid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic wait_for_responses();
    while (regs_sb.outstanding() != 0) @(posedge clk);
  endtask

  initial begin
    int n;
    forever begin
      @(negedge clk);
      if (stall_receiver) begin
        m_tready <= 1'b0;
        repeat (LONG_STALL - 1) @(negedge clk);
        stall_receiver = 1'b0;
      end else if (!quiet && $urandom_range(0, 99) < 15) begin
        m_tready <= 1'b0;
        n = $urandom_range(1, 17);
        repeat (n - 1) @(negedge clk);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) regs_sb.check_response(m_tdata);
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Run stopped after %0d cycles with %0d responses outstanding.",
             cycles, regs_sb.outstanding());
    $display("** dual_timer_watchdog_regs: FAILED **");
    $finish;
  end

  initial begin
    int i;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    m_tready = 1'b0;
    quiet = 1'b0;
    stall_receiver = 1'b0;
    regs_sb = new();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_request(make_req(MODE_READ, OFS_T0_DATA, 32'd0, 4'h0, 1'b0, 1'b0));
    send_request(make_req(MODE_WRITE, OFS_T0_DIV, 32'd3, 4'h0, 1'b0, 1'b0));
    send_request(make_req(MODE_WRITE, OFS_T0_CTRL, {27'd0, 3'd4, OP_LOAD}, 4'h0, 1'b0, 1'b0));
    send_request(make_req(MODE_WRITE, OFS_T0_CTRL, {27'd0, 3'd4, OP_RUN}, 4'h0, 1'b0, 1'b0));
    send_request(make_req(MODE_TICK, 7'd0, 32'd0, 4'hf, 1'b0, 1'b1));
    send_request(make_req(MODE_WRITE, OFS_T1_DIV, 32'hffff_ffff, 4'h0, 1'b0, 1'b0));
    send_request(make_req(MODE_WRITE, OFS_T1_CTRL, {27'd0, 3'd1, OP_RUN}, 4'h0, 1'b0, 1'b0));
    send_request(make_req(MODE_TICK, 7'h7f, 32'hffff_ffff, 4'hf, 1'b1, 1'b1));
    send_request(make_req(MODE_READ, OFS_T1_DATA, 32'd0, 4'h0, 1'b0, 1'b0));
    send_request(make_req(MODE_WRITE, OFS_T1_CTRL, {27'h7ff_ffff, 3'd7, OP_KEEP},
                          4'h0, 1'b0, 1'b0));
    send_request(make_req(MODE_TICK, 7'd0, 32'd0, 4'h8, 1'b0, 1'b0));
    send_request(make_req(MODE_WRITE, OFS_MASK, 32'hffff_ffff, 4'h0, 1'b0, 1'b0));
    send_request(make_req(MODE_READ, OFS_MASKED, 32'd0, 4'h0, 1'b0, 1'b0));
    send_request(make_req(MODE_WRITE, OFS_ACK, 32'd2, 4'h0, 1'b0, 1'b0));
    send_request(make_req(MODE_WRITE, OFS_WD_CTRL, 32'h0000_0100, 4'h0, 1'b0, 1'b0));
    send_request(make_req(MODE_WRITE, OFS_WD_CTRL, 32'h0000_0105, 4'h0, 1'b0, 1'b0));
    send_request(make_req(MODE_WRITE, OFS_WD_CTRL, 32'h0000_ff01, 4'h0, 1'b0, 1'b0));
    send_request(make_req(MODE_TICK, 7'd0, 32'd0, 4'h0, 1'b1, 1'b0));
    send_request(make_req(MODE_WRITE, OFS_T0_CTRL, {27'd0, 3'd4, OP_HOLD}, 4'h0, 1'b0, 1'b0));
    send_request(make_req(MODE_WRITE, OFS_UNMAPPED, 32'hdead_beef, 4'h0, 1'b0, 1'b0));
    send_request(make_req(MODE_READ, 7'h05, 32'd0, 4'h0, 1'b0, 1'b0));
    send_request(make_req(MODE_READ, 7'h7f, 32'd0, 4'h0, 1'b0, 1'b0));
    send_request(make_req(MODE_NONE, OFS_MASK, 32'hffff_ffff, 4'hf, 1'b1, 1'b1));
    send_request(make_req(MODE_READ, OFS_TIME, 32'd0, 4'h0, 1'b0, 1'b0));
    send_request(make_req(MODE_WRITE, OFS_WD_CTRL, 32'h0000_0000, 4'h0, 1'b0, 1'b0));
    send_request(make_req(MODE_READ, OFS_WD_CTRL, 32'd0, 4'h0, 1'b0, 1'b0));

    for (i = 0; i < RANDOM_ITEMS; i++) begin
      quiet = (i >= RANDOM_ITEMS - QUIET_ITEMS);
      if (i == 300) stall_receiver = 1'b1;
      if (i == 500) begin
        pause_sender(1);
        wait_for_responses();
      end
      if (!quiet && $urandom_range(0, 99) < 12) pause_sender($urandom_range(1, 17));
      send_request(random_request());
    end
    pause_sender(1);
    wait_for_responses();
    repeat (4) @(posedge clk);

    $display("Sent %0d reads, %0d writes and %0d ticks; %0d responses checked.",
             reads_sent, writes_sent, ticks_sent, regs_sb.checked);
    $display("Responses showed irq %0d times, nmi %0d times, %0d reset requests.",
             regs_sb.irq_seen, regs_sb.nmi_seen, regs_sb.resets_seen);
    if (regs_sb.mismatches == 0 && regs_sb.outstanding() == 0) begin
      $display("** dual_timer_watchdog_regs: PASSED **");
    end else begin
      $display("%0d mismatches, %0d responses missing.",
               regs_sb.mismatches, regs_sb.outstanding());
      $display("** dual_timer_watchdog_regs: FAILED **");
    end
    $finish;
  end

endmodule
